// File: rtl/core/assert_macros.svh
// Assertion macros shared by the relay scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with asynchronous reset disable
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// clocked invariant with asynchronous reset disable
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

// File: rtl/core/frds_pkg.sv
// Package: types and constants for the flood relay dedup scheduler
package frds_pkg;
  localparam int unsigned SeenSlotsDef = 8;
  localparam int unsigned PendSlotsDef = 4;
  localparam logic [7:0] FrameMagic = 8'h57;
  localparam logic [7:0] FrameMinLen = 8'd8;

  localparam logic [2:0] CfgNodeId   = 3'd0;
  localparam logic [2:0] CfgSnrRef   = 3'd1;
  localparam logic [2:0] CfgDlyBase  = 3'd2;
  localparam logic [2:0] CfgDlyPerDb = 3'd3;
  localparam logic [2:0] CfgDlyMax   = 3'd4;

  localparam logic [2:0] KindRxErr   = 3'd0;
  localparam logic [2:0] KindIgnored = 3'd1;
  localparam logic [2:0] KindDupSupp = 3'd2;
  localparam logic [2:0] KindDup     = 3'd3;
  localparam logic [2:0] KindSched   = 3'd4;
  localparam logic [2:0] KindFull    = 3'd5;
  localparam logic [2:0] KindFire    = 3'd6;
  localparam logic [2:0] KindIdle    = 3'd7;

  // classified item passed from front to back
  typedef struct packed {
    logic        tick;
    logic        rx_err;
    logic        ignored;
    logic [31:0] now_ms;
    logic [31:0] src_id;
    logic [15:0] msg_id;
    logic [16:0] delay_ms;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  slot;
    logic [31:0] out_source;
    logic [15:0] out_message;
    logic [14:0] seq_gap;
    logic        last;
  } res_t;
endpackage

// File: rtl/core/flood_relay_dedup_scheduler.sv
// Top level of the flood relay dedup scheduler
// Usage:
//   Input channel in_valid/in_stall carries one item: a received frame
//   (func_i = 0) or a tick (func_i = 1). Result channel out_valid/out_stall
//   carries result items; last_o marks the final result of an input item.
//   Config channel cfg_valid/cfg_ready writes register cfg_index with cfg_data;
//   always ready. The user must write it only while idle; not enforced.
//   An accepted item leaves the front in the accept cycle and is written into
//   the queue; the back pops it only while idle into job_q, and a frame result
//   is then registered in res_q. A tick walks one pending slot per cycle while
//   the output is not stalled, one result per fire, or one idle result if none
//   fires. The back takes no new item until it is through with the last one.
//   A two-entry queue lets the front accept while the back works.
//   Reset clears seen ring, pending slots and sequence tracking and loads the
//   default delay registers. A stalled result holds; the back waits, the queue
//   fills and in_stall rises.
module flood_relay_dedup_scheduler import frds_pkg::*; #(
  parameter int unsigned SeenSlots = SeenSlotsDef,
  parameter int unsigned PendSlots = PendSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func_i,
  input  logic [31:0] now_ms_i,
  input  logic        rx_ok_i,
  input  logic [7:0]  frame_len_i,
  input  logic [7:0]  magic_i,
  input  logic [31:0] src_id_i,
  input  logic [15:0] msg_id_i,
  input  logic signed [7:0] snr_qdb_i,
  input  logic        snr_valid_i,
  input  logic [7:0]  jitter_ms_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind_o,
  output logic [1:0]  slot_o,
  output logic [31:0] out_source_o,
  output logic [15:0] out_message_o,
  output logic [14:0] seq_gap_o,
  output logic        last_o
);
  logic job_valid, q_full, q_valid, q_pop;
  job_t job, q_job;
  res_t res;

  frds_front u_front (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .func_i, .now_ms_i, .rx_ok_i, .frame_len_i, .magic_i,
    .src_id_i, .msg_id_i, .snr_qdb_i, .snr_valid_i, .jitter_ms_i,
    .job_valid_o(job_valid), .job_full_i(q_full), .job_o(job)
  );

  frds_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_valid), .push_data_i(job), .full_o(q_full),
    .pop_valid_o(q_valid), .pop_i(q_pop), .pop_data_o(q_job)
  );

  frds_back #(.SeenSlots(SeenSlots), .PendSlots(PendSlots)) u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_pop_o(q_pop), .job_i(q_job),
    .res_valid_o(out_valid), .res_stall_i(out_stall), .res_o(res)
  );

  assign kind_o = res.kind;
  assign slot_o = res.slot;
  assign out_source_o = res.out_source;
  assign out_message_o = res.out_message;
  assign seq_gap_o = res.seq_gap;
  assign last_o = res.last;
endmodule

// File: rtl/core/frds_front.sv
// Front end: checks frames and computes rebroadcast delay
module frds_front import frds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func_i,
  input  logic [31:0] now_ms_i,
  input  logic        rx_ok_i,
  input  logic [7:0]  frame_len_i,
  input  logic [7:0]  magic_i,
  input  logic [31:0] src_id_i,
  input  logic [15:0] msg_id_i,
  input  logic signed [7:0] snr_qdb_i,
  input  logic        snr_valid_i,
  input  logic [7:0]  jitter_ms_i,
  output logic        job_valid_o,
  input  logic        job_full_i,
  output job_t        job_o
);
  logic [31:0] node_id_q;
  logic signed [7:0] snr_ref_q;
  logic [15:0] base_q, max_q;
  logic [9:0]  perdb_q;
  logic signed [8:0] diff;
  logic [6:0]  over;
  logic [16:0] prod, sum, clamp;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;
  assign in_stall = job_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
      snr_ref_q <= '0;
      base_q <= 16'd100;
      perdb_q <= 10'd20;
      max_q <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgNodeId:   node_id_q <= cfg_data;
        CfgSnrRef:   snr_ref_q <= cfg_data[7:0];
        CfgDlyBase:  base_q <= cfg_data[15:0];
        CfgDlyPerDb: perdb_q <= cfg_data[9:0];
        CfgDlyMax:   max_q <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff = 9'(snr_ref_q) - 9'(snr_qdb_i);
    over = (snr_valid_i && !diff[8]) ? diff[8:2] : 7'd0;
    prod = 17'(over) * 17'(perdb_q);
    sum = 17'(base_q) + prod;
    clamp = (sum > 17'(max_q)) ? 17'(max_q) : sum;
  end

  always_comb begin
    job_valid_o = in_valid && !job_full_i;
    job_o.tick = func_i;
    job_o.rx_err = !rx_ok_i;
    job_o.ignored = (frame_len_i < FrameMinLen) || (magic_i != FrameMagic) ||
                    (src_id_i == node_id_q);
    job_o.now_ms = now_ms_i;
    job_o.src_id = src_id_i;
    job_o.msg_id = msg_id_i;
    job_o.delay_ms = clamp + 17'(jitter_ms_i);
  end
endmodule

// File: rtl/core/frds_queue.sv
// Two-entry item queue between front and back
module frds_queue import frds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q[1];
  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, pop_valid_o)
  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
endmodule

// File: rtl/core/frds_back.sv
// Back end: dedup ring, pending slots, scheduling and firing
module frds_back import frds_pkg::*; #(
  parameter int unsigned SeenSlots = SeenSlotsDef,
  parameter int unsigned PendSlots = PendSlotsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_pop_o,
  input  job_t job_i,
  output logic res_valid_o,
  input  logic res_stall_i,
  output res_t res_o
);
  localparam int unsigned SW = (SeenSlots > 1) ? $clog2(SeenSlots) : 1;
  localparam int unsigned PW = (PendSlots > 1) ? $clog2(PendSlots) : 1;

  typedef enum logic [1:0] {StIdle, StFire, StOut} state_e;
  state_e st_q;

  logic [31:0] seen_src_q [SeenSlots];
  logic [15:0] seen_msg_q [SeenSlots];
  logic [SeenSlots-1:0] seen_vld_q;
  logic [SW-1:0] seen_next_q;
  logic [PendSlots-1:0] pact_q;
  logic [31:0] psrc_q [PendSlots];
  logic [15:0] pmsg_q [PendSlots];
  logic [31:0] pdue_q [PendSlots];
  logic [15:0] last_seq_q;
  logic have_last_q;

  job_t job_q;
  logic [PW-1:0] idx_q;
  logic [2:0] nfire_q;
  logic any_q;
  res_t res_q;
  logic rvalid_q;

  logic [SeenSlots-1:0] hit;
  logic [PendSlots-1:0] pmatch;
  logic [PendSlots-1:0] due_vec;
  logic [PW-1:0] free_idx, dup_idx;
  logic free_any, dup_any;
  logic [15:0] gd;
  logic [14:0] gap;
  logic [31:0] fdiff [PendSlots];
  logic fire_now, last_idx, out_free;
  logic more_due, fire_go, fire_last, emit;

  assign out_free = !rvalid_q || !res_stall_i;
  assign res_valid_o = rvalid_q;
  assign res_o = res_q;
  assign job_pop_o = (st_q == StIdle) && job_valid_i;

  always_comb begin
    for (int i = 0; i < SeenSlots; i++) begin
      hit[i] = seen_vld_q[i] && seen_src_q[i] == job_q.src_id &&
               seen_msg_q[i] == job_q.msg_id;
    end
    for (int p = 0; p < PendSlots; p++) begin
      pmatch[p] = pact_q[p] && psrc_q[p] == job_q.src_id &&
                  pmsg_q[p] == job_q.msg_id;
      fdiff[p] = job_q.now_ms - pdue_q[p];
      due_vec[p] = pact_q[p] && !fdiff[p][31];
    end
    free_any = 1'b0;
    free_idx = '0;
    dup_any = 1'b0;
    dup_idx = '0;
    for (int p = PendSlots - 1; p >= 0; p--) begin
      if (!pact_q[p]) begin
        free_any = 1'b1;
        free_idx = PW'(p);
      end
      if (pmatch[p]) begin
        dup_any = 1'b1;
        dup_idx = PW'(p);
      end
    end
    more_due = 1'b0;
    for (int p = 0; p < PendSlots; p++) begin
      if (p > int'(idx_q) && due_vec[p]) more_due = 1'b1;
    end
    gd = job_q.msg_id - (last_seq_q + 16'd1);
    gap = (have_last_q && !gd[15]) ? gd[14:0] : 15'd0;
    fire_now = due_vec[idx_q];
    last_idx = 32'(idx_q) == PendSlots - 1;
    fire_go = fire_now && nfire_q < 3'd4;
    fire_last = !more_due || nfire_q == 3'd3;
    emit = out_free && (st_q == StOut || (st_q == StFire &&
           (fire_go || ((last_idx || nfire_q == 3'd4) && !any_q))));
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      seen_vld_q <= '0;
      seen_next_q <= '0;
      pact_q <= '0;
      last_seq_q <= '0;
      have_last_q <= 1'b0;
      idx_q <= '0;
      nfire_q <= '0;
      any_q <= 1'b0;
      rvalid_q <= 1'b0;
      res_q <= '0;
      for (int i = 0; i < SeenSlots; i++) begin
        seen_src_q[i] <= '0;
        seen_msg_q[i] <= '0;
      end
    end else begin
      if (emit) rvalid_q <= 1'b1;
      else if (!res_stall_i) rvalid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (job_pop_o) begin
            st_q <= job_i.tick ? StFire : StOut;
            idx_q <= '0;
            nfire_q <= '0;
            any_q <= 1'b0;
          end
        end
        StFire: begin
          if (out_free) begin
            if (fire_go) begin
              pact_q[idx_q] <= 1'b0;
              nfire_q <= nfire_q + 3'd1;
              any_q <= 1'b1;
              res_q <= '{KindFire, 2'(idx_q), psrc_q[idx_q], pmsg_q[idx_q], 15'd0,
                         fire_last};
              if (fire_last) st_q <= StIdle;
              else idx_q <= idx_q + PW'(1);
            end else if (last_idx || nfire_q == 3'd4) begin
              st_q <= StIdle;
              if (!any_q) begin
                res_q <= '{KindIdle, 2'd0, 32'd0, 16'd0, 15'd0, 1'b1};
              end
            end else begin
              idx_q <= idx_q + PW'(1);
            end
          end
        end
        StOut: begin
          if (out_free) begin
            st_q <= StIdle;
            if (job_q.rx_err) begin
              res_q <= '{KindRxErr, 2'd0, 32'd0, 16'd0, 15'd0, 1'b1};
            end else if (job_q.ignored) begin
              res_q <= '{KindIgnored, 2'd0, job_q.src_id, job_q.msg_id, 15'd0, 1'b1};
            end else if (|hit) begin
              if (dup_any) begin
                pact_q[dup_idx] <= 1'b0;
                res_q <= '{KindDupSupp, 2'd0, job_q.src_id, job_q.msg_id, 15'd0, 1'b1};
              end else begin
                res_q <= '{KindDup, 2'd0, job_q.src_id, job_q.msg_id, 15'd0, 1'b1};
              end
            end else begin
              seen_src_q[seen_next_q] <= job_q.src_id;
              seen_msg_q[seen_next_q] <= job_q.msg_id;
              seen_vld_q[seen_next_q] <= 1'b1;
              seen_next_q <= (32'(seen_next_q) == SeenSlots - 1) ? '0
                             : seen_next_q + SW'(1);
              last_seq_q <= job_q.msg_id;
              have_last_q <= 1'b1;
              if (free_any) begin
                pact_q[free_idx] <= 1'b1;
                res_q <= '{KindSched, 2'(free_idx), job_q.src_id, job_q.msg_id, gap, 1'b1};
              end else begin
                res_q <= '{KindFull, 2'd0, job_q.src_id, job_q.msg_id, gap, 1'b1};
              end
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StOut && out_free && !job_q.rx_err && !job_q.ignored && !(|hit) &&
        free_any) begin
      psrc_q[free_idx] <= job_q.src_id;
      pmsg_q[free_idx] <= job_q.msg_id;
      pdue_q[free_idx] <= job_q.now_ms + 32'(job_q.delay_ms);
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, job_pop_o, st_q == StIdle)
  `ASSERT_ALWAYS(a_fire_cap, clk_i, rst_ni, nfire_q <= 3'd4)
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, rvalid_q && res_stall_i, ##1 rvalid_q)
  `ASSERT_ALWAYS(a_pcnt, clk_i, rst_ni, $countones(pact_q) <= int'(PendSlots))
endmodule

// File: tb/testbench.sv
// Self-checking testbench of the flood relay dedup scheduler: predicts results, checks each one
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import frds_pkg::*;

  typedef struct {
    logic        func;
    logic [31:0] now;
    logic        rx_ok;
    logic [7:0]  len;
    logic [7:0]  magic;
    logic [31:0] src;
    logic [15:0] msg;
    logic [7:0]  snr;
    logic        snr_valid;
    logic [7:0]  jitter;
  } relay_item_t;

  class relay_sb;
    logic [31:0] node_id;
    logic [7:0]  snr_ref;
    logic [15:0] dly_base;
    logic [9:0]  dly_per_db;
    logic [15:0] dly_max;
    logic [31:0] seen_src[8];
    logic [15:0] seen_msg[8];
    bit          seen_vld[8];
    int          seen_wr;
    bit          pend_act[4];
    logic [31:0] pend_src[4];
    logic [15:0] pend_msg[4];
    logic [31:0] pend_due[4];
    logic [15:0] last_seq;
    bit          have_last;
    res_t        expq[$];

    function new();
      node_id = 0; snr_ref = 0; dly_base = 100; dly_per_db = 20; dly_max = 1000;
      for (int i = 0; i < 8; i++) begin
        seen_src[i] = 0; seen_msg[i] = 0; seen_vld[i] = 0;
      end
      for (int i = 0; i < 4; i++) pend_act[i] = 0;
      seen_wr = 0; last_seq = 0; have_last = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CfgNodeId:   node_id = v;
        CfgSnrRef:   snr_ref = v[7:0];
        CfgDlyBase:  dly_base = v[15:0];
        CfgDlyPerDb: dly_per_db = v[9:0];
        CfgDlyMax:   dly_max = v[15:0];
        default: ;
      endcase
    endfunction

    function void push(logic [2:0] k, logic [1:0] sl, logic [31:0] s, logic [15:0] m,
                       logic [14:0] g, logic l);
      res_t r;
      r.kind = k; r.slot = sl; r.out_source = s; r.out_message = m;
      r.seq_gap = g; r.last = l;
      expq.push_back(r);
    endfunction

    function void note_item(relay_item_t it);
      res_t fires[$];
      res_t r;
      logic [31:0] diff, d, over;
      logic [15:0] dg;
      logic [14:0] gap;
      int sd;
      int h;
      if (it.func) begin
        for (int i = 0; i < 4; i++) begin
          diff = it.now - pend_due[i];
          if (pend_act[i] && !diff[31]) begin
            pend_act[i] = 0;
            r.kind = KindFire; r.slot = 2'(i); r.out_source = pend_src[i];
            r.out_message = pend_msg[i]; r.seq_gap = 0; r.last = 0;
            fires.push_back(r);
          end
        end
        if (fires.size() == 0) begin
          push(KindIdle, 0, 0, 0, 0, 1);
        end else begin
          foreach (fires[i]) begin
            r = fires[i];
            r.last = (i == fires.size() - 1);
            expq.push_back(r);
          end
        end
        return;
      end
      if (!it.rx_ok) begin
        push(KindRxErr, 0, 0, 0, 0, 1);
        return;
      end
      if (it.len < FrameMinLen || it.magic != FrameMagic || it.src == node_id) begin
        push(KindIgnored, 0, it.src, it.msg, 0, 1);
        return;
      end
      for (int i = 0; i < 8; i++) begin
        if (seen_vld[i] && seen_src[i] == it.src && seen_msg[i] == it.msg) begin
          for (int p = 0; p < 4; p++) begin
            if (pend_act[p] && pend_src[p] == it.src && pend_msg[p] == it.msg) begin
              pend_act[p] = 0;
              push(KindDupSupp, 0, it.src, it.msg, 0, 1);
              return;
            end
          end
          push(KindDup, 0, it.src, it.msg, 0, 1);
          return;
        end
      end
      h = seen_wr;
      seen_src[h] = it.src; seen_msg[h] = it.msg; seen_vld[h] = 1;
      seen_wr = (h + 1) % 8;
      gap = 0;
      if (have_last) begin
        dg = it.msg - (last_seq + 16'd1);
        if (dg != 0 && !dg[15]) gap = dg[14:0];
      end
      last_seq = it.msg; have_last = 1;
      for (int i = 0; i < 4; i++) begin
        if (!pend_act[i]) begin
          over = 0;
          if (it.snr_valid) begin
            sd = $signed(snr_ref) - $signed(it.snr);
            if (sd > 0) over = sd >> 2;
          end
          d = dly_base + over * dly_per_db;
          if (d > dly_max) d = dly_max;
          d = d + it.jitter;
          pend_act[i] = 1; pend_src[i] = it.src; pend_msg[i] = it.msg;
          pend_due[i] = it.now + d;
          push(KindSched, 2'(i), it.src, it.msg, gap, 1);
          return;
        end
      end
      push(KindFull, 0, it.src, it.msg, gap, 1);
    endfunction

    function string check_result(res_t got);
      res_t e;
      string s;
      if (expq.size() == 0) return "result with no expected item waiting";
      e = expq.pop_front();
      s = "";
      if (got.kind !== e.kind) s = {s, $sformatf(" kind %0d/%0d", got.kind, e.kind)};
      if (got.slot !== e.slot) s = {s, $sformatf(" slot %0d/%0d", got.slot, e.slot)};
      if (got.out_source !== e.out_source)
        s = {s, $sformatf(" src %h/%h", got.out_source, e.out_source)};
      if (got.out_message !== e.out_message)
        s = {s, $sformatf(" msg %h/%h", got.out_message, e.out_message)};
      if (got.seq_gap !== e.seq_gap)
        s = {s, $sformatf(" gap %0d/%0d", got.seq_gap, e.seq_gap)};
      if (got.last !== e.last) s = {s, $sformatf(" last %0d/%0d", got.last, e.last)};
      return s;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic func_i = 0;
  logic [31:0] now_ms_i = 0;
  logic rx_ok_i = 0;
  logic [7:0] frame_len_i = 0;
  logic [7:0] magic_i = 0;
  logic [31:0] src_id_i = 0;
  logic [15:0] msg_id_i = 0;
  logic signed [7:0] snr_qdb_i = 0;
  logic snr_valid_i = 0;
  logic [7:0] jitter_ms_i = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] kind_o;
  logic [1:0] slot_o;
  logic [31:0] out_source_o;
  logic [15:0] out_message_o;
  logic [14:0] seq_gap_o;
  logic last_o;

  flood_relay_dedup_scheduler uut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  relay_sb sb = new();
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] cur_now = 32'd1000;
  logic [31:0] src_pool[4];
  logic [31:0] hist_src[8];
  logic [15:0] hist_msg[8];
  int hist_wr = 0;
  logic [15:0] next_msg = 0;

  task automatic report(string s);
    $display("MISMATCH at %0t:%s", $realtime, s);
    errors++;
  endtask

  always @(posedge clk_i) begin
    res_t got;
    string s;
    if (rst_ni && out_valid && !out_stall) begin
      got.kind = kind_o; got.slot = slot_o; got.out_source = out_source_o;
      got.out_message = out_message_o; got.seq_gap = seq_gap_o; got.last = last_o;
      s = sb.check_result(got);
      if (s != "") report(s);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(relay_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1;
    func_i <= it.func; now_ms_i <= it.now; rx_ok_i <= it.rx_ok; frame_len_i <= it.len;
    magic_i <= it.magic; src_id_i <= it.src; msg_id_i <= it.msg; snr_qdb_i <= it.snr;
    snr_valid_i <= it.snr_valid; jitter_ms_i <= it.jitter;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 0;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  function automatic relay_item_t frame(logic [31:0] s, logic [15:0] m, logic [7:0] snr,
                                        logic sv, logic [7:0] j);
    relay_item_t it;
    it.func = 0; it.now = cur_now; it.rx_ok = 1; it.len = 8; it.magic = FrameMagic;
    it.src = s; it.msg = m; it.snr = snr; it.snr_valid = sv; it.jitter = j;
    return it;
  endfunction

  function automatic relay_item_t tick(logic [31:0] t);
    relay_item_t it;
    it = frame(0, 0, 0, 0, 0);
    it.func = 1; it.now = t;
    return it;
  endfunction

  task automatic directed();
    relay_item_t it;
    send_item(tick(cur_now));
    it = frame(32'h11, 0, 0, 1, 0); it.rx_ok = 0; send_item(it);
    it = frame(32'h11, 1, 0, 1, 0); it.len = 7; send_item(it);
    it = frame(32'h11, 2, 0, 1, 0); it.len = 0; send_item(it);
    it = frame(32'h11, 3, 0, 1, 0); it.magic = 8'hA8; send_item(it);
    send_item(frame(32'h0, 4, 0, 1, 0));
    drain();
    write_reg(CfgNodeId, 32'hFFFF_FFFF);
    send_item(frame(32'hFFFF_FFFF, 5, 0, 1, 0));
    send_item(frame(32'h0, 16'h0000, 8'sd127, 1, 8'd0));
    it = frame(32'h22, 16'hFFFF, 8'h80, 1, 8'd255); it.len = 255; send_item(it);
    send_item(frame(32'h33, 16'h0005, 8'h80, 0, 8'd17));
    send_item(frame(32'h44, 16'h7FFF, 8'hF0, 1, 8'd3));
    send_item(frame(32'h55, 16'h8000, 8'h00, 1, 8'd0));
    send_item(frame(32'h22, 16'hFFFF, 8'h80, 1, 8'd0));
    send_item(frame(32'h22, 16'hFFFF, 8'h80, 1, 8'd0));
    send_item(frame(32'h55, 16'h8000, 8'h00, 1, 8'd0));
    send_item(tick(cur_now + 32'd50));
    send_item(tick(cur_now + 32'd5000));
    send_item(tick(cur_now + 32'd5000));
    drain();
  endtask

  task automatic random_items(int n);
    relay_item_t it;
    int r;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      r = $urandom_range(99);
      cur_now = cur_now + $urandom_range(0, 300);
      if (r < 3) cur_now = $urandom;
      if (r < 30) begin
        if ($urandom_range(9) == 0) it = tick(cur_now + 32'd70000);
        else it = tick(cur_now);
      end else begin
        it = frame(src_pool[$urandom_range(3)], next_msg, 8'($urandom),
                   1'($urandom_range(1)), 8'($urandom));
        r = $urandom_range(99);
        if (r < 25) begin
          it.src = hist_src[$urandom_range(7)];
          it.msg = hist_msg[$urandom_range(7)];
        end else if (r < 35) begin
          it.msg = 16'($urandom);
        end else begin
          it.msg = 16'(next_msg + $urandom_range(0, 3));
        end
        it.len = 8'($urandom_range(8, 255));
        r = $urandom_range(99);
        if (r < 5) it.rx_ok = 0;
        else if (r < 10) it.len = 8'($urandom_range(0, 7));
        else if (r < 15) it.magic = 8'($urandom);
        else if (r < 18) it.src = sb.node_id;
        else if (r < 21) it.src = $urandom;
        if (it.rx_ok && it.len >= 8 && it.magic == FrameMagic) begin
          hist_src[hist_wr] = it.src; hist_msg[hist_wr] = it.msg;
          hist_wr = (hist_wr + 1) % 8;
          next_msg = it.msg + 16'd1;
        end
      end
      send_item(it);
    end
    drain();
  endtask

  task automatic phase(int idle, int stall, logic [31:0] nid, logic [7:0] ref_q,
                       logic [15:0] base, logic [9:0] per_db, logic [15:0] dmax);
    write_reg(CfgNodeId, nid);
    write_reg(CfgSnrRef, {24'd0, ref_q});
    write_reg(CfgDlyBase, {16'd0, base});
    write_reg(CfgDlyPerDb, {22'd0, per_db});
    write_reg(CfgDlyMax, {16'd0, dmax});
    foreach (src_pool[i]) src_pool[i] = $urandom;
    src_pool[0] = nid ^ 32'h1;
    send_idle_pct = idle;
    stall_pct = stall;
    random_items(120);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      hist_src[i] = 32'h11; hist_msg[i] = 16'(i);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    directed();
    phase(0, 0, 32'h0, 8'h00, 16'd100, 10'd20, 16'd1000);
    phase(51, 0, 32'hFFFF_FFFF, 8'h7F, 16'd0, 10'd1023, 16'd65535);
    phase(0, 51, $urandom, 8'h80, 16'd65535, 10'd0, 16'd0);
    phase(21, 21, $urandom, 8'h10, 16'd30, 10'd7, 16'd400);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/frds_pkg.sv
rtl/core/frds_front.sv
rtl/core/frds_queue.sv
rtl/core/frds_back.sv
rtl/core/flood_relay_dedup_scheduler.sv
tb/testbench.sv
